// ===== hw/rtl/bfsm_pkg.sv =====
// ----------------------------------------------------------------------------
// Bloom filter string member package
// Shared sizes and the controller state type of the Bloom filter block.
// ----------------------------------------------------------------------------
package bfsm_pkg;

  localparam int CELLS     = 1024;
  localparam int CELL_AW   = $clog2(CELLS);
  localparam int CELL_CW   = CELL_AW + 1;
  localparam int HASH_W    = 32;
  localparam int CHAR_W    = 8;
  localparam int NCELL_W   = 11;
  localparam int BITCNT_W  = $clog2(HASH_W);

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_MOD   = 7'b0000100,
    S_MEMA  = 7'b0001000,
    S_MEMB  = 7'b0010000,
    S_MEMC  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

endpackage

// ===== hw/rtl/bfsm_char_if.sv =====
// ----------------------------------------------------------------------------
// Character channel
// Carries one character of a word with its action and last mark.
// ----------------------------------------------------------------------------
interface bfsm_char_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [bfsm_pkg::CHAR_W-1:0] char_code;
  logic                       last;

  modport source (output valid, output action, output char_code, output last,
                  input ready);
  modport sink   (input valid, input action, input char_code, input last,
                  output ready);
endinterface

// ===== hw/rtl/bfsm_res_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Carries the membership answer for one finished word.
// ----------------------------------------------------------------------------
interface bfsm_res_if;
  logic valid;
  logic ready;
  logic found;
  logic was_query;

  modport source (output valid, output found, output was_query, input ready);
  modport sink   (input valid, input found, input was_query, output ready);
endinterface

// ===== hw/rtl/bfsm_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration channel
// Carries a write of the cell count register.
// ----------------------------------------------------------------------------
interface bfsm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bfsm_pkg::NCELL_W-1:0] num_cells;

  modport source (output valid, output num_cells, input ready);
  modport sink   (input valid, input num_cells, output ready);
endinterface

// ===== hw/rtl/bloom_filter_string_member_unit.sv =====
// ----------------------------------------------------------------------------
// Bloom filter string member unit
// Two-hash Bloom filter over words delivered one character per item.
// ----------------------------------------------------------------------------
// Words arrive on in_i one character per item; the item with last set ends
// the word and carries the action that counts (insert or query). Each
// character updates a rotate-xor hash and a times-33 hash, so characters
// inside a word are taken back to back.
// On the last character both hashes are reduced modulo the cell count by a
// restoring remainder unit that retires one dividend bit per cycle, then
// the one-bit cell memory is accessed at both indices through its single
// port: two writes for an insert, two registered reads for a query.
// One item per word leaves on res_o and sits in an output register; the
// next word's characters are taken while it waits, and only the end of that
// next word stalls until res_o is free.
// cfg_i writes num_cells, always ready; 0 or values above the cell count
// select the full cell count.
// After reset a clearing pass writes zero to all 1024 cells, one a cycle,
// while in_i stays not ready.
// ----------------------------------------------------------------------------
module bloom_filter_string_member_unit (
  input  logic clk_i,
  input  logic rst_ni,
  bfsm_char_if.sink   in_i,
  bfsm_cfg_if.sink    cfg_i,
  bfsm_res_if.source  res_o
);

  localparam int AW = bfsm_pkg::CELL_AW;
  localparam int CW = bfsm_pkg::CELL_CW;
  localparam int HW = bfsm_pkg::HASH_W;
  localparam int BW = bfsm_pkg::BITCNT_W;

  bfsm_pkg::state_e state_q, state_d;

  logic [bfsm_pkg::NCELL_W-1:0] ncell_q;
  logic [HW-1:0]  rot_q, rot_d, t33_q, t33_d;
  logic [HW-1:0]  div0_q, div1_q;
  logic [AW-1:0]  rem0_q, rem1_q, rem0_d, rem1_d;
  logic [CW-1:0]  trial0, trial1;
  logic [CW-1:0]  mod_q, mod_d;
  logic [BW-1:0]  bit_cnt_q;
  logic [AW-1:0]  clr_cnt_q;
  logic           query_q;
  logic           bit0_q;
  logic           found_q;
  logic           out_valid_q, out_found_q, out_query_q;
  logic [HW-1:0]  char_ext;
  logic           in_fire;
  logic           out_free;

  logic           mem_q [bfsm_pkg::CELLS];
  logic           mem_we, mem_wdata, mem_re, rd_q;
  logic [AW-1:0]  mem_addr;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || res_o.ready;
  assign in_i.ready  = (state_q == bfsm_pkg::S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign res_o.valid     = out_valid_q;
  assign res_o.found     = out_found_q;
  assign res_o.was_query = out_query_q;

  assign char_ext = {{(HW - bfsm_pkg::CHAR_W){in_i.char_code[bfsm_pkg::CHAR_W-1]}},
                     in_i.char_code};
  assign rot_d = {rot_q[HW-5:0], 4'b0000} ^ {28'd0, rot_q[HW-1:HW-4]} ^ char_ext;
  assign t33_d = {t33_q[HW-6:0], 5'b00000} + t33_q + char_ext;

  always_comb begin
    if ((ncell_q == '0) || (32'(ncell_q) > 32'(bfsm_pkg::CELLS))) begin
      mod_d = CW'(bfsm_pkg::CELLS);
    end else begin
      mod_d = CW'(ncell_q);
    end
  end

  assign trial0 = {rem0_q, div0_q[HW-1]};
  assign trial1 = {rem1_q, div1_q[HW-1]};
  assign rem0_d = (trial0 >= mod_q) ? AW'(trial0 - mod_q) : AW'(trial0);
  assign rem1_d = (trial1 >= mod_q) ? AW'(trial1 - mod_q) : AW'(trial1);

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = 1'b1;
    mem_re    = 1'b0;
    mem_addr  = rem0_q;
    state_d   = state_q;
    case (state_q)
      bfsm_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = 1'b0;
        mem_addr  = clr_cnt_q;
        if (clr_cnt_q == AW'(bfsm_pkg::CELLS - 1)) begin
          state_d = bfsm_pkg::S_IDLE;
        end
      end
      bfsm_pkg::S_IDLE: begin
        if (in_fire && in_i.last) begin
          state_d = bfsm_pkg::S_MOD;
        end
      end
      bfsm_pkg::S_MOD: begin
        if (bit_cnt_q == BW'(HW - 1)) begin
          state_d = bfsm_pkg::S_MEMA;
        end
      end
      bfsm_pkg::S_MEMA: begin
        mem_addr = rem0_q;
        mem_we   = (query_q == bfsm_pkg::ACT_INSERT);
        mem_re   = (query_q == bfsm_pkg::ACT_QUERY);
        state_d  = bfsm_pkg::S_MEMB;
      end
      bfsm_pkg::S_MEMB: begin
        mem_addr = rem1_q;
        mem_we   = (query_q == bfsm_pkg::ACT_INSERT);
        mem_re   = (query_q == bfsm_pkg::ACT_QUERY);
        state_d  = (query_q == bfsm_pkg::ACT_QUERY) ? bfsm_pkg::S_MEMC : bfsm_pkg::S_DONE;
      end
      bfsm_pkg::S_MEMC: begin
        state_d = bfsm_pkg::S_DONE;
      end
      bfsm_pkg::S_DONE: begin
        if (out_free) begin
          state_d = bfsm_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bfsm_pkg::S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfsm_pkg::S_CLEAR;
      clr_cnt_q   <= '0;
      ncell_q     <= bfsm_pkg::NCELL_W'(1024);
      rot_q       <= '0;
      t33_q       <= '0;
      bit_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        ncell_q <= cfg_i.num_cells;
      end
      if (state_q == bfsm_pkg::S_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (in_fire) begin
        if (in_i.last) begin
          rot_q <= '0;
          t33_q <= '0;
        end else begin
          rot_q <= rot_d;
          t33_q <= t33_d;
        end
      end
      if (state_q == bfsm_pkg::S_MOD) begin
        bit_cnt_q <= bit_cnt_q + BW'(1);
      end else begin
        bit_cnt_q <= '0;
      end
      if ((state_q == bfsm_pkg::S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_i.last) begin
      div0_q  <= rot_d;
      div1_q  <= t33_d;
      rem0_q  <= '0;
      rem1_q  <= '0;
      mod_q   <= mod_d;
      query_q <= in_i.action;
    end else if (state_q == bfsm_pkg::S_MOD) begin
      div0_q <= {div0_q[HW-2:0], 1'b0};
      div1_q <= {div1_q[HW-2:0], 1'b0};
      rem0_q <= rem0_d;
      rem1_q <= rem1_d;
    end
    if (state_q == bfsm_pkg::S_MEMA) begin
      found_q <= 1'b1;
    end
    if (state_q == bfsm_pkg::S_MEMB) begin
      bit0_q <= rd_q;
    end
    if (state_q == bfsm_pkg::S_MEMC) begin
      found_q <= bit0_q & rd_q;
    end
    if ((state_q == bfsm_pkg::S_DONE) && out_free) begin
      out_found_q <= found_q;
      out_query_q <= query_q;
    end
  end

endmodule
